### rtl/ntr_pkg.sv
// Package for the neighbor table tree router: opcodes, constants, shared types.
// No dependencies.
package ntr_pkg;

    localparam logic [15:0] NONE_ADDR     = 16'hFFFF;
    localparam logic [15:0] USE_LONG_ADDR = 16'hFFFE;
    localparam int unsigned CAP_ROUTER_BIT = 1;
    localparam int unsigned CAP_ALLOC_BIT  = 7;

    typedef enum logic [3:0] {
        OP_CLEAR      = 4'd0,
        OP_FIND_LONG  = 4'd1,
        OP_FIND_SHORT = 4'd2,
        OP_CHECK_PAIR = 4'd3,
        OP_MAP_PAIR   = 4'd4,
        OP_ADD_CHILD  = 4'd5,
        OP_DEL_SHORT  = 4'd6,
        OP_DEL_LONG   = 4'd7,
        OP_ROUTE      = 4'd8,
        OP_SHORT_LONG = 4'd9
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_OWN    = 3'd0,
        CFG_PARENT = 3'd1,
        CFG_CSKIP1 = 3'd2,
        CFG_CSKIP2 = 3'd3,
        CFG_MAXR   = 3'd4,
        CFG_MAXE   = 3'd5,
        CFG_COORD  = 3'd6
    } t_cfg_index;

    // Per-slot compare flags from the shared match unit.
    typedef struct packed {
        logic long_eq;
        logic short_eq;
        logic in_range;
        logic short_none;
    } t_match;

endpackage

### rtl/ntr_match.sv
// Shared compare unit for one slot per cycle: equality and router range test.
// Depends on ntr_pkg.
module ntr_match (
    input  logic [63:0]     i_slot_long,
    input  logic [15:0]     i_slot_short,
    input  logic [63:0]     i_key_long,
    input  logic [15:0]     i_key_short,
    input  logic [15:0]     i_range_top,
    output ntr_pkg::t_match o_match
);
    always_comb begin
        o_match.long_eq    = (i_slot_long == i_key_long);
        o_match.short_eq   = (i_slot_short == i_key_short);
        o_match.in_range   = (i_key_short >= i_slot_short) && (i_key_short <= i_range_top);
        o_match.short_none = (i_slot_short == ntr_pkg::NONE_ADDR);
    end
endmodule

### rtl/neighbor_table_tree_router_core.sv
// Top level of the neighbor table tree router: sequencer, slot store, cfg regs.
// Depends on ntr_pkg and ntr_match.
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------
//  command   | i_opcode i_long_addr i_short_addr i_cap_info   | i_start & !o_busy
//  result    | o_found o_entry_index o_result_short_addr      | o_done, one cycle
//            | o_result_long_addr                             |
//  config    | i_cfg_we i_cfg_index i_cfg_data                | i_cfg_we, no wait
//
// Steps: an item goes from the accepting edge to its result through the states
// S_TOP, S_SCAN, S_COMMIT and S_DONE (capture with the Cskip products, own range
// top, a scan of one slot per cycle through the shared compare unit, commit,
// result strobe). o_busy drops in the o_done cycle; no new item is taken while
// one is in flight. Clear takes the same path.
// Reset (synchronous, i_rst_n low) invalidates every slot and reloads the
// address assignment state; the long address and capability stores have no
// reset. The receiver cannot stall: o_done is high for exactly one cycle.
module neighbor_table_tree_router_core #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_opcode,
    input  logic [63:0] i_long_addr,
    input  logic [15:0] i_short_addr,
    input  logic [7:0]  i_cap_info,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic        o_found,
    output logic [3:0]  o_entry_index,
    output logic [15:0] o_result_short_addr,
    output logic [63:0] o_result_long_addr
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_TOP, S_SCAN, S_COMMIT, S_DONE
    } t_state;

    // configuration
    logic [15:0] r_own, r_parent, r_cskip1, r_cskip2;
    logic [7:0]  r_maxr, r_maxe;
    logic        r_coord;

    // slot store
    logic [ENTRIES-1:0] r_valid;
    logic [15:0]        r_short [ENTRIES];
    logic [63:0]        r_long  [ENTRIES];
    logic [7:0]         r_cap   [ENTRIES];

    // address assignment
    logic [15:0] r_next_router, r_next_end;
    logic [7:0]  r_rcount, r_ecount;

    // command and scan state
    t_state      r_state;
    logic [3:0]  r_op;
    logic [63:0] r_key_long;
    logic [15:0] r_key_short;
    logic [7:0]  r_key_cap;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic        r_hit, r_free;
    logic [15:0] r_top_own;   // own range top
    logic [23:0] r_prod2;     // cskip_grandchild * max_routers
    logic [23:0] r_prod1;     // cskip_child * max_routers

    logic [IW-1:0]  w_idx;
    ntr_pkg::t_match w_m;
    logic [15:0]    w_rtop;
    logic           w_hit, w_free;

    assign w_idx = r_cnt[IW-1:0];
    assign w_rtop = 16'(r_short[w_idx] + r_prod2[15:0] + {8'd0, r_maxe});

    ntr_match u_match (
        .i_slot_long (r_long[w_idx]),
        .i_slot_short(r_short[w_idx]),
        .i_key_long  (r_key_long),
        .i_key_short (r_key_short),
        .i_range_top (w_rtop),
        .o_match     (w_m)
    );

    // per-slot hit for the current opcode
    always_comb begin
        w_hit  = 1'b0;
        w_free = 1'b0;
        case (r_op)
            ntr_pkg::OP_FIND_LONG, ntr_pkg::OP_DEL_LONG:
                w_hit = r_valid[w_idx] && w_m.long_eq;
            ntr_pkg::OP_FIND_SHORT, ntr_pkg::OP_DEL_SHORT, ntr_pkg::OP_SHORT_LONG:
                w_hit = r_valid[w_idx] && w_m.short_eq;
            ntr_pkg::OP_CHECK_PAIR, ntr_pkg::OP_MAP_PAIR:
                w_hit = r_valid[w_idx] && w_m.short_eq && w_m.long_eq;
            ntr_pkg::OP_ROUTE:
                w_hit = r_valid[w_idx] && (r_cap[w_idx][ntr_pkg::CAP_ROUTER_BIT]
                        ? w_m.in_range : w_m.short_eq);
            default: w_hit = 1'b0;
        endcase
        if (r_op == ntr_pkg::OP_MAP_PAIR)
            w_free = !r_valid[w_idx] || w_m.short_none;
        else
            w_free = !r_valid[w_idx];
    end

    assign o_busy = (r_state != S_IDLE);

    logic        w_route_pre, w_route_err;
    logic [15:0] w_assign;
    always_comb begin
        w_route_err = (r_key_short == r_own);
        w_route_pre = (r_key_short == 16'd0) ||
            (!r_coord && !((r_key_short > r_own) && (r_key_short <= r_top_own)));
        if (!r_key_cap[ntr_pkg::CAP_ALLOC_BIT])
            w_assign = ntr_pkg::USE_LONG_ADDR;
        else if (r_key_cap[ntr_pkg::CAP_ROUTER_BIT])
            w_assign = r_next_router;
        else
            w_assign = r_next_end;
    end

    // slot store reset and writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) r_short[i] <= ntr_pkg::NONE_ADDR;
        end else if (r_state == S_COMMIT) begin
            case (r_op)
                ntr_pkg::OP_CLEAR: begin
                    r_valid <= '0;
                    for (int i = 0; i < ENTRIES; i++) r_short[i] <= ntr_pkg::NONE_ADDR;
                end
                ntr_pkg::OP_MAP_PAIR: begin
                    if (!r_hit && r_free) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_short[r_free_idx] <= r_key_short;
                        r_long[r_free_idx]  <= r_key_long;
                    end
                end
                ntr_pkg::OP_ADD_CHILD: begin
                    if (r_free) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_short[r_free_idx] <= w_assign;
                        r_long[r_free_idx]  <= r_key_long;
                        r_cap[r_free_idx]   <= r_key_cap;
                    end
                end
                ntr_pkg::OP_DEL_SHORT, ntr_pkg::OP_DEL_LONG: begin
                    if (r_hit) begin
                        r_valid[r_hit_idx] <= 1'b0;
                        r_short[r_hit_idx] <= ntr_pkg::NONE_ADDR;
                    end
                end
                default: ;
            endcase
        end
    end

    // sequencer, config, assignment state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
            r_own <= '0; r_parent <= '0; r_cskip1 <= '0; r_cskip2 <= '0;
            r_maxr <= 8'd4; r_maxe <= 8'd13; r_coord <= 1'b0;
            r_rcount <= '0; r_ecount <= '0;
            r_next_router <= 16'd1;
            r_next_end    <= 16'd1;  // own 0, cskip 0 at reset
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ntr_pkg::CFG_OWN:    r_own    <= i_cfg_data;
                    ntr_pkg::CFG_PARENT: r_parent <= i_cfg_data;
                    ntr_pkg::CFG_CSKIP1: r_cskip1 <= i_cfg_data;
                    ntr_pkg::CFG_CSKIP2: r_cskip2 <= i_cfg_data;
                    ntr_pkg::CFG_MAXR:   r_maxr   <= i_cfg_data[7:0];
                    ntr_pkg::CFG_MAXE:   r_maxe   <= i_cfg_data[7:0];
                    ntr_pkg::CFG_COORD:  r_coord  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op        <= i_opcode;
                        r_key_long  <= i_long_addr;
                        r_key_short <= i_short_addr;
                        r_key_cap   <= i_cap_info;
                        r_prod1     <= r_cskip1[15:0] * r_maxr;
                        r_prod2     <= r_cskip2[15:0] * r_maxr;
                        r_state     <= S_TOP;
                    end
                end
                S_TOP: begin
                    // hold own range top; reset scan
                    r_top_own <= 16'(r_own + r_prod1[15:0] + {8'd0, r_maxe});
                    r_cnt   <= '0;
                    r_hit   <= 1'b0;
                    r_free  <= 1'b0;
                    r_hit_idx  <= '0;
                    r_free_idx <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_hit && (!r_hit || r_op == ntr_pkg::OP_SHORT_LONG)) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= w_idx;
                    end
                    if (w_free && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= w_idx;
                    end
                    if (r_cnt == CW'(ENTRIES - 1)) r_state <= S_COMMIT;
                    else r_cnt <= r_cnt + 1'b1;
                end
                S_COMMIT: begin
                    o_found <= 1'b0;
                    o_entry_index <= '0;
                    o_result_short_addr <= ntr_pkg::NONE_ADDR;
                    o_result_long_addr  <= '0;
                    case (r_op)
                        ntr_pkg::OP_CLEAR: begin
                            r_rcount <= '0;
                            r_ecount <= '0;
                            r_next_router <= r_own + 16'd1;
                            r_next_end    <= 16'(r_own + 16'd1 + r_prod1[15:0]);
                        end
                        ntr_pkg::OP_FIND_LONG, ntr_pkg::OP_FIND_SHORT,
                        ntr_pkg::OP_CHECK_PAIR, ntr_pkg::OP_SHORT_LONG: begin
                            if (r_hit) begin
                                o_found <= 1'b1;
                                o_entry_index <= 4'(r_hit_idx);
                                o_result_short_addr <= r_short[r_hit_idx];
                                if (r_op == ntr_pkg::OP_SHORT_LONG)
                                    o_result_long_addr <= r_long[r_hit_idx];
                            end
                        end
                        ntr_pkg::OP_MAP_PAIR: begin
                            if (r_hit) begin
                                o_found <= 1'b1;
                                o_entry_index <= 4'(r_hit_idx);
                                o_result_short_addr <= r_short[r_hit_idx];
                            end else if (r_free) begin
                                o_found <= 1'b1;
                                o_entry_index <= 4'(r_free_idx);
                                o_result_short_addr <= 16'd0;
                            end
                        end
                        ntr_pkg::OP_ADD_CHILD: begin
                            if (r_free) begin
                                o_found <= 1'b1;
                                o_entry_index <= 4'(r_free_idx);
                                o_result_short_addr <= w_assign;
                                if (r_key_cap[ntr_pkg::CAP_ROUTER_BIT]) begin
                                    r_rcount <= r_rcount + 8'd1;
                                    if (r_key_cap[ntr_pkg::CAP_ALLOC_BIT])
                                        r_next_router <= r_next_router + r_cskip1;
                                end else begin
                                    r_ecount <= r_ecount + 8'd1;
                                    if (r_key_cap[ntr_pkg::CAP_ALLOC_BIT])
                                        r_next_end <= r_next_end + 16'd1;
                                end
                            end
                        end
                        ntr_pkg::OP_DEL_SHORT, ntr_pkg::OP_DEL_LONG: begin
                            if (r_hit) begin
                                o_found <= 1'b1;
                                o_entry_index <= 4'(r_hit_idx);
                            end
                        end
                        ntr_pkg::OP_ROUTE: begin
                            if (w_route_err) begin
                                o_found <= 1'b0;
                            end else if (w_route_pre) begin
                                o_found <= 1'b1;
                                o_result_short_addr <= r_parent;
                            end else if (r_hit) begin
                                o_found <= 1'b1;
                                o_entry_index <= 4'(r_hit_idx);
                                o_result_short_addr <= r_short[r_hit_idx];
                            end
                        end
                        default: ;
                    endcase
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/ntr_checker.sv
// Port-level checker for the neighbor table tree router, with its bind.
// Depends on neighbor_table_tree_router_core ports only.
module ntr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic        o_found,
    input logic [15:0] o_result_short_addr,
    input logic [63:0] o_result_long_addr
);
    // accepted item makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy after start");
    // done is one cycle and ends busy
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    // a long address is reported only with a hit
    a_long_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_result_long_addr == 64'd0))
        else $error("long address without hit");
endmodule

bind neighbor_table_tree_router_core ntr_checker u_ntr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_found(o_found),
    .o_result_short_addr(o_result_short_addr),
    .o_result_long_addr(o_result_long_addr)
);

### tb/neighbor_table_tree_router_core_tb.sv
// Self-checking testbench for neighbor_table_tree_router_core.
// Runs directed and random items against a built-in predictor; depends on ntr_pkg and the core.
module neighbor_table_tree_router_core_tb;

    localparam int ENTRIES = 16;
    localparam int DRAIN_CYCLES = ENTRIES + 10;
    localparam int ITEMS_PER_PHASE = 425;

    typedef struct packed {
        logic        found;
        logic [3:0]  idx;
        logic [15:0] short_addr;
        logic [63:0] long_addr;
    } t_table_result;

    typedef struct {
        logic [3:0]    op;
        logic [63:0]   la;
        logic [15:0]   sa;
        logic [7:0]    cap;
        bit            typed;
        t_table_result res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [3:0]  i_opcode;
    logic [63:0] i_long_addr;
    logic [15:0] i_short_addr;
    logic [7:0]  i_cap_info;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_done;
    logic        o_found;
    logic [3:0]  o_entry_index;
    logic [15:0] o_result_short_addr;
    logic [63:0] o_result_long_addr;

    neighbor_table_tree_router_core #(.ENTRIES(ENTRIES)) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_opcode            (i_opcode),
        .i_long_addr         (i_long_addr),
        .i_short_addr        (i_short_addr),
        .i_cap_info          (i_cap_info),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_done              (o_done),
        .o_found             (o_found),
        .o_entry_index       (o_entry_index),
        .o_result_short_addr (o_result_short_addr),
        .o_result_long_addr  (o_result_long_addr)
    );

    // Shadow copy of the table and registers.
    bit          tbl_valid [ENTRIES];
    logic [15:0] tbl_short [ENTRIES];
    logic [63:0] tbl_long  [ENTRIES];
    logic [7:0]  tbl_cap   [ENTRIES];
    bit          cap_known [ENTRIES];
    logic [15:0] nxt_router, nxt_end;
    logic [7:0]  router_cnt, end_cnt;
    logic [15:0] cfg_own, cfg_parent, cfg_cskip1, cfg_cskip2;
    logic [7:0]  cfg_maxr, cfg_maxe;
    logic        cfg_coord;

    t_table_result pending_q [$];
    logic [63:0]   long_pool [8];
    int            err_cnt = 0;
    int            item_cnt = 0;
    int            result_cnt = 0;
    bit            no_idle = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] range_top(input logic [15:0] base, input logic [15:0] cskip);
        logic [31:0] v;
        v = 32'(base) + 32'(cskip) * 32'(cfg_maxr) + 32'(cfg_maxe);
        return v[15:0];
    endfunction

    function automatic int pair_slot(input logic [63:0] la, input logic [15:0] sa);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_short[i] == sa && tbl_long[i] == la) return i;
        return -1;
    endfunction

    task automatic reload_assign();
        logic [31:0] v;
        v = 32'(cfg_own) + 32'd1 + 32'(cfg_cskip1) * 32'(cfg_maxr);
        router_cnt = 0;
        end_cnt    = 0;
        nxt_router = cfg_own + 16'd1;
        nxt_end    = v[15:0];
    endtask

    task automatic wipe_table();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 0;
            tbl_short[i] = ntr_pkg::NONE_ADDR;
        end
        reload_assign();
    endtask

    // Compute the result of one accepted item and advance the shadow table.
    task automatic predict_table(input logic [3:0] op, input logic [63:0] la,
                                 input logic [15:0] sa, input logic [7:0] cap,
                                 output t_table_result r);
        int k;
        int i;
        logic [15:0] a;
        bit hit;
        k = -1;
        r = '{found: 1'b0, idx: 4'd0, short_addr: ntr_pkg::NONE_ADDR, long_addr: 64'd0};
        case (op)
            ntr_pkg::OP_CLEAR: wipe_table();
            ntr_pkg::OP_FIND_LONG: begin
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_long[i] == la) begin k = i; break; end
            end
            ntr_pkg::OP_FIND_SHORT: begin
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_short[i] == sa) begin k = i; break; end
            end
            ntr_pkg::OP_CHECK_PAIR: k = pair_slot(la, sa);
            ntr_pkg::OP_MAP_PAIR: begin
                k = pair_slot(la, sa);
                if (k < 0) begin
                    for (i = 0; i < ENTRIES; i++)
                        if (!tbl_valid[i] || tbl_short[i] == ntr_pkg::NONE_ADDR) break;
                    if (i < ENTRIES) begin
                        tbl_long[i]  = la;
                        tbl_short[i] = sa;
                        tbl_valid[i] = 1;
                        r.found = 1; r.idx = i[3:0]; r.short_addr = 16'd0;
                    end
                end
            end
            ntr_pkg::OP_ADD_CHILD: begin
                for (i = 0; i < ENTRIES; i++)
                    if (!tbl_valid[i]) break;
                if (i < ENTRIES) begin
                    if (cap[ntr_pkg::CAP_ROUTER_BIT]) begin
                        if (cap[ntr_pkg::CAP_ALLOC_BIT]) begin
                            a = nxt_router;
                            nxt_router = nxt_router + cfg_cskip1;
                        end else a = ntr_pkg::USE_LONG_ADDR;
                        router_cnt = router_cnt + 8'd1;
                    end else begin
                        if (cap[ntr_pkg::CAP_ALLOC_BIT]) begin
                            a = nxt_end;
                            nxt_end = nxt_end + 16'd1;
                        end else a = ntr_pkg::USE_LONG_ADDR;
                        end_cnt = end_cnt + 8'd1;
                    end
                    tbl_valid[i] = 1;
                    tbl_cap[i]   = cap;
                    cap_known[i] = 1;
                    tbl_long[i]  = la;
                    tbl_short[i] = a;
                    r.found = 1; r.idx = i[3:0]; r.short_addr = a;
                end
            end
            ntr_pkg::OP_DEL_SHORT, ntr_pkg::OP_DEL_LONG: begin
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && ((op == ntr_pkg::OP_DEL_SHORT) ? tbl_short[i] == sa
                                                                       : tbl_long[i] == la)) begin
                        tbl_valid[i] = 0;
                        tbl_short[i] = ntr_pkg::NONE_ADDR;
                        r.found = 1; r.idx = i[3:0];
                        break;
                    end
            end
            ntr_pkg::OP_ROUTE: begin
                if (sa != cfg_own) begin
                    if (sa == 16'd0 || (!cfg_coord &&
                        !(sa > cfg_own && sa <= range_top(cfg_own, cfg_cskip1)))) begin
                        r.found = 1; r.short_addr = cfg_parent;
                    end else begin
                        for (i = 0; i < ENTRIES; i++) begin
                            if (!tbl_valid[i]) continue;
                            if (tbl_cap[i][ntr_pkg::CAP_ROUTER_BIT])
                                hit = sa >= tbl_short[i] &&
                                      sa <= range_top(tbl_short[i], cfg_cskip2);
                            else
                                hit = sa == tbl_short[i];
                            if (hit) begin
                                r.found = 1; r.idx = i[3:0]; r.short_addr = tbl_short[i];
                                break;
                            end
                        end
                    end
                end
            end
            ntr_pkg::OP_SHORT_LONG: begin
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_short[i] == sa) k = i;
                if (k >= 0) r.long_addr = tbl_long[k];
            end
            default: ;
        endcase
        if (k >= 0) begin
            r.found = 1; r.idx = k[3:0]; r.short_addr = tbl_short[k];
        end
    endtask

    // Drive one item at the current edge and hold it until the core takes it.
    task automatic send_item(input logic [3:0] op_in, input logic [63:0] la,
                             input logic [15:0] sa, input logic [7:0] cap,
                             input bit typed, input t_table_result typed_res);
        int i;
        logic [3:0] op;
        t_table_result r;
        op = op_in;
        // Never let a map pair land on a slot whose capability was never written.
        if (op == ntr_pkg::OP_MAP_PAIR && pair_slot(la, sa) < 0) begin
            for (i = 0; i < ENTRIES; i++)
                if (!tbl_valid[i] || tbl_short[i] == ntr_pkg::NONE_ADDR) break;
            if (i < ENTRIES && !cap_known[i]) op = ntr_pkg::OP_ADD_CHILD;
        end
        i_start      <= 1'b1;
        i_opcode     <= op;
        i_long_addr  <= la;
        i_short_addr <= sa;
        i_cap_info   <= cap;
        do @(posedge i_clk); while (o_busy);
        predict_table(op, la, sa, cap, r);
        pending_q.push_back(typed ? typed_res : r);
        item_cnt++;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] own, input logic [15:0] parent,
                                input logic [15:0] cs1, input logic [15:0] cs2,
                                input logic [7:0] mr, input logic [7:0] me,
                                input logic [15:0] coord);
        logic [15:0] vals [7];
        vals = '{own, parent, cs1, cs2, {8'd0, mr}, {8'd0, me}, coord};
        wait_drained();
        for (int i = 0; i < 7; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_own    = own;
        cfg_parent = parent;
        cfg_cskip1 = cs1;
        cfg_cskip2 = cs2;
        cfg_maxr   = mr;
        cfg_maxe   = me;
        cfg_coord  = coord[0];
    endtask

    function automatic logic [63:0] pick_long();
        int s;
        s = $urandom_range(0, ENTRIES - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return tbl_valid[s] ? tbl_long[s] : long_pool[$urandom_range(0, 7)];
            4, 5, 6, 7: return long_pool[$urandom_range(0, 7)];
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_short();
        int s;
        s = $urandom_range(0, ENTRIES - 1);
        case ($urandom_range(0, 9))
            0, 1, 2: return tbl_short[s];
            3:       return tbl_short[s] + 16'($urandom_range(1, 30));
            4:       return cfg_own;
            5, 6:    return cfg_own + 16'($urandom_range(1, 40));
            7:       return $urandom_range(0, 1) ? 16'd0 : ntr_pkg::NONE_ADDR;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 2)  return ntr_pkg::OP_CLEAR;
        if (w < 4)  return 4'($urandom_range(10, 15));
        if (w < 30) return ntr_pkg::OP_ADD_CHILD;
        if (w < 40) return ntr_pkg::OP_MAP_PAIR;
        if (w < 50) return ntr_pkg::OP_FIND_LONG;
        if (w < 58) return ntr_pkg::OP_FIND_SHORT;
        if (w < 64) return ntr_pkg::OP_CHECK_PAIR;
        if (w < 70) return ntr_pkg::OP_DEL_SHORT;
        if (w < 76) return ntr_pkg::OP_DEL_LONG;
        if (w < 90) return ntr_pkg::OP_ROUTE;
        return ntr_pkg::OP_SHORT_LONG;
    endfunction

    // Compare every result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_table_result got;
            t_table_result want;
            got = '{o_found, o_entry_index, o_result_short_addr, o_result_long_addr};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result found=%0b idx=%0d short=%h long=%h",
                         $time, got.found, got.idx, got.short_addr, got.long_addr);
                err_cnt++;
            end else begin
                want = pending_q.pop_front();
                result_cnt++;
                if (got !== want) begin
                    $display("%0t: mismatch exp found=%0b idx=%0d short=%h long=%h",
                             $time, want.found, want.idx, want.short_addr, want.long_addr);
                    $display("%0t:          got found=%0b idx=%0d short=%h long=%h",
                             $time, got.found, got.idx, got.short_addr, got.long_addr);
                    err_cnt++;
                end
            end
        end
    end

    t_stim_row dir_rows [$];
    t_table_result no_hit;

    initial begin
        no_hit = '{1'b0, 4'd0, ntr_pkg::NONE_ADDR, 64'd0};
        // Directed table under the reset register values (own 0, no Cskip).
        dir_rows = '{
            '{ntr_pkg::OP_FIND_SHORT, 64'd0, ntr_pkg::NONE_ADDR, 8'h00, 1, no_hit},
            '{4'd15, '1, '1, 8'hFF, 1, no_hit},
            '{ntr_pkg::OP_ROUTE, 64'd0, 16'd0, 8'h00, 1, no_hit},
            '{ntr_pkg::OP_ADD_CHILD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 8'h82, 1,
              '{1'b1, 4'd0, 16'h0001, 64'd0}},
            '{ntr_pkg::OP_ADD_CHILD, 64'd0, 16'd0, 8'h00, 1,
              '{1'b1, 4'd1, ntr_pkg::USE_LONG_ADDR, 64'd0}},
            '{ntr_pkg::OP_ADD_CHILD, 64'h0123_4567_89AB_CDEF, 16'd0, 8'h80, 1,
              '{1'b1, 4'd2, 16'h0001, 64'd0}},
            '{ntr_pkg::OP_ADD_CHILD, 64'hDEAD_BEEF_0000_0001, 16'd0, 8'h02, 0, no_hit},
            '{ntr_pkg::OP_FIND_LONG, 64'h0123_4567_89AB_CDEF, 16'd0, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_FIND_SHORT, 64'd0, 16'h0001, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_CHECK_PAIR, 64'h0123_4567_89AB_CDEF, 16'h0001, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_MAP_PAIR, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_DEL_SHORT, 64'd0, ntr_pkg::USE_LONG_ADDR, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_MAP_PAIR, 64'h5555_AAAA_5555_AAAA, 16'h1234, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_SHORT_LONG, 64'd0, 16'h0001, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_ROUTE, 64'd0, 16'h0001, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_ROUTE, 64'd0, 16'h0005, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_ROUTE, 64'd0, 16'h8000, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_DEL_LONG, 64'h0123_4567_89AB_CDEF, 16'd0, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_DEL_LONG, 64'h7777_0000_7777_0000, 16'd0, 8'h00, 0, no_hit},
            '{ntr_pkg::OP_MAP_PAIR, 64'h0F0F_0F0F_0F0F_0F0F, ntr_pkg::NONE_ADDR, 8'h00, 0,
              no_hit},
            '{ntr_pkg::OP_CLEAR, 64'd0, 16'd0, 8'h00, 1, no_hit},
            '{ntr_pkg::OP_FIND_LONG, 64'd0, 16'd0, 8'h00, 1, no_hit}
        };

        i_rst_n = 0; i_start = 0; i_opcode = '0; i_long_addr = '0; i_short_addr = '0;
        i_cap_info = '0; i_cfg_we = 0; i_cfg_index = '0; i_cfg_data = '0;
        for (int i = 0; i < 8; i++) long_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_long[i] = '0; tbl_cap[i] = '0; cap_known[i] = 0;
        end
        cfg_own = 0; cfg_parent = 0; cfg_cskip1 = 0; cfg_cskip2 = 0;
        cfg_maxr = 8'd4; cfg_maxe = 8'd13; cfg_coord = 0;
        wipe_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n])
            send_item(dir_rows[n].op, dir_rows[n].la, dir_rows[n].sa, dir_rows[n].cap,
                      dir_rows[n].typed, dir_rows[n].res);
        i_start <= 1'b0;

        // Random phases: coordinator, mid-depth router, all ones, all zeros.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: program_regs(16'd0, 16'd0, 16'd1446, 16'd358, 8'd6, 8'd14, 16'd1);
                1: program_regs(16'd1447, 16'd0, 16'd358, 16'd86, 8'd6, 8'd14, 16'd0);
                2: program_regs('1, '1, '1, '1, 8'hFF, 8'hFF, 16'hFFFF);
                default: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0);
            endcase
            @(posedge i_clk);
            // Start each phase from a clean table so assignment uses the new registers.
            send_item(ntr_pkg::OP_CLEAR, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                      0, no_hit);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                no_idle = (ph == 1 && n >= 100 && n < 400);
                if (n == 200 && ph == 2) begin
                    // Hold off the sender until every pending result has come back.
                    i_start <= 1'b0;
                    while (pending_q.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end else if (!no_idle && $urandom_range(0, 99) < 21) begin
                    i_start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
                send_item(pick_op(), pick_long(), pick_short(), 8'($urandom), 0, no_hit);
            end
            i_start <= 1'b0;
        end

        wait_drained();
        $display("ran %0d items, %0d results, over reset, coordinator, router, extreme",
                 item_cnt, result_cnt);
        $display("and zero register settings with random gaps between commands");
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
